FILE: hw/rtl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked at every rising edge outside reset
`define AST_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define AST_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define AST_NOW(label, clk, rst, ante, cons)
`define AST_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/padac_pkg.sv
// constants, codes and the phase quantiser for the phase to dac frame block
`timescale 1ns / 1ps
package padac_pkg;

   localparam int DEF_ELEMENTS = 64;
   localparam int IDX_W        = 6;
   localparam int PHASE_W      = 16;
   localparam int CODE_W       = 12;
   localparam int CMD_W        = 6;
   localparam int BYTE_W       = 8;

   // operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_STEER = 1'b1;

   // write-and-update command in the top bits of the command byte
   localparam logic [CMD_W-4:0] CMD_WRITE_UPDATE = 3'b110;

   // round(4095 * phase / 32768), full scale at or above a half turn
   function automatic logic [CODE_W-1:0] quantise(input logic [PHASE_W-1:0] phase);
      logic [26:0] prod;
      logic [26:0] sum;
      prod = {phase[PHASE_W-2:0], 12'd0} - {12'd0, phase[PHASE_W-2:0]};
      sum  = prod + 27'd16384;
      if (phase[PHASE_W-1]) begin
         return {CODE_W{1'b1}};
      end
      return sum[26:15];
   endfunction

endpackage

FILE: hw/rtl/phased_array_phase_to_dac_frames_top.sv
// phased array phase to dac code and frame converter, top level
// an accepted beat passes the work register, then the result register, to rsp_
// write beats: one per cycle unless stalled, one frame each (dropped past the array size)
// steer beats: ELEMENTS frames, one per cycle unless stalled, set by the element sequencer
// reset (synchronous, active high) clears the element counter and both valids
`timescale 1ns / 1ps
`include "assert_macros.svh"
module phased_array_phase_to_dac_frames_top
   import padac_pkg::*;
#(
   parameter int ELEMENTS = DEF_ELEMENTS
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_operation,
   input  logic [PHASE_W-1:0]  req_phase_value,
   input  logic                req_last_element,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [IDX_W-1:0]    rsp_element_index,
   output logic [CODE_W-1:0]   rsp_dac_code,
   output logic [CMD_W-1:0]    rsp_command_byte,
   output logic [BYTE_W-1:0]   rsp_high_byte,
   output logic [BYTE_W-1:0]   rsp_low_byte,
   output logic                rsp_end_of_run
);

   // counter has to hold ELEMENTS itself (saturated state)
   localparam int                CNT_W    = $clog2(ELEMENTS + 1);
   localparam logic [CNT_W-1:0]  ELEM_CNT = CNT_W'(ELEMENTS);
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(ELEMENTS - 1);

   // element counter for write mode
   logic [CNT_W-1:0]    element_counter_ff, element_counter_in;

   // work register: the frame about to be quantised
   logic                wrk_valid_ff, wrk_valid_in;
   logic                wrk_steer_ff, wrk_steer_in;
   logic [IDX_W-1:0]    wrk_index_ff, wrk_index_in;
   logic [PHASE_W-1:0]  wrk_phase_ff, wrk_phase_in;
   logic [PHASE_W-1:0]  wrk_step_ff, wrk_step_in;
   logic                wrk_end_ff, wrk_end_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]    rsp_index_ff;
   logic [CODE_W-1:0]   rsp_code_ff;
   logic                rsp_end_ff;

   logic                rsp_take;
   logic                adv;
   logic                wrk_final;
   logic                req_acc;
   logic                room;
   logic [CODE_W-1:0]   code;

   // result slot is free or being emptied this cycle
   assign rsp_take  = !rsp_valid_ff || rsp_ready;
   assign adv       = wrk_valid_ff && rsp_take;
   // write frames are single; steer finishes on the last element
   assign wrk_final = !wrk_steer_ff || (wrk_index_ff == LAST_IDX);
   assign req_ready = !wrk_valid_ff || (adv && wrk_final);
   assign req_acc   = req_valid && req_ready;
   assign room      = element_counter_ff < ELEM_CNT;

   assign code = quantise(wrk_phase_ff);

   always_comb begin
      element_counter_in = element_counter_ff;
      wrk_valid_in       = wrk_valid_ff;
      wrk_steer_in       = wrk_steer_ff;
      wrk_index_in       = wrk_index_ff;
      wrk_phase_in       = wrk_phase_ff;
      wrk_step_in        = wrk_step_ff;
      wrk_end_in         = wrk_end_ff;

      // steer sequencer: next element, phase grows by one step; a final frame empties the work register
      if (adv) begin
         if (wrk_final) begin
            wrk_valid_in = 1'b0;
         end else begin
            wrk_index_in = wrk_index_ff + IDX_W'(1);
            wrk_phase_in = wrk_phase_ff + wrk_step_ff;
            wrk_end_in   = (wrk_index_ff + IDX_W'(1)) == LAST_IDX;
         end
      end

      if (req_acc) begin
         if (req_operation == OP_STEER) begin
            wrk_valid_in       = 1'b1;
            wrk_steer_in       = 1'b1;
            wrk_index_in       = '0;
            wrk_phase_in       = '0;
            wrk_step_in        = req_phase_value;
            wrk_end_in         = (LAST_IDX == '0);
            element_counter_in = '0;
         end else begin
            // beats past the array size are dropped
            wrk_valid_in = room;
            wrk_steer_in = 1'b0;
            wrk_index_in = IDX_W'(element_counter_ff);
            wrk_phase_in = req_phase_value;
            wrk_step_in  = req_phase_value;
            wrk_end_in   = req_last_element;
            if (req_last_element) begin
               element_counter_in = '0;
            end else if (room) begin
               element_counter_in = element_counter_ff + CNT_W'(1);
            end
         end
      end

      if (adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         element_counter_ff <= '0;
         wrk_valid_ff       <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         element_counter_ff <= element_counter_in;
         wrk_valid_ff       <= wrk_valid_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      wrk_steer_ff <= wrk_steer_in;
      wrk_index_ff <= wrk_index_in;
      wrk_phase_ff <= wrk_phase_in;
      wrk_step_ff  <= wrk_step_in;
      wrk_end_ff   <= wrk_end_in;
      if (adv) begin
         rsp_index_ff <= wrk_index_ff;
         rsp_code_ff  <= code;
         rsp_end_ff   <= wrk_end_ff;
      end
   end

   // frame packing straight off the result register
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_element_index = rsp_index_ff;
   assign rsp_dac_code      = rsp_code_ff;
   assign rsp_command_byte  = {CMD_WRITE_UPDATE, rsp_index_ff[2:0]};
   assign rsp_high_byte     = rsp_code_ff[CODE_W-1:4];
   assign rsp_low_byte      = {rsp_code_ff[3:0], 4'd0};
   assign rsp_end_of_run    = rsp_end_ff;

   // counter never passes the array size
   `AST_NOW(a_cnt_bound, clock, reset, 1'b1, element_counter_ff <= ELEM_CNT)
   // a steer beat starts the sequencer at element zero
   `AST_NEXT(a_steer_start, clock, reset, req_acc && (req_operation == OP_STEER),
             wrk_valid_ff && wrk_steer_ff && (wrk_index_ff == '0))
   // a stalled sequencer keeps its element
   `AST_NEXT(a_steer_hold, clock, reset, wrk_valid_ff && !adv,
             wrk_valid_ff && $stable(wrk_index_ff) && $stable(wrk_phase_ff))
   // a new beat is taken only when the work register empties
   `AST_NOW(a_ready_frees, clock, reset, req_ready && wrk_valid_ff, adv && wrk_final)

endmodule

FILE: tb/sv/phased_array_phase_to_dac_frames_top_tb.sv
// self-checking testbench for the phase to dac frame converter
`timescale 1ns / 1ps
module phased_array_phase_to_dac_frames_top_tb
   import padac_pkg::*;
;

   localparam int N_ELEM      = DEF_ELEMENTS;
   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_BEATS = 180;

   // one request beat as the sender offers it
   typedef struct {
      logic               op;
      logic [PHASE_W-1:0] phase;
      logic               last;
   } phase_beat_type;

   // one dac write frame as the block should return it
   typedef struct {
      logic [IDX_W-1:0]  index;
      logic [CODE_W-1:0] code;
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] hi;
      logic [BYTE_W-1:0] lo;
      logic              run_end;
   } dac_frame_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_operation = OP_WRITE;
   logic [PHASE_W-1:0]  req_phase_value = '0;
   logic                req_last_element = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [IDX_W-1:0]    rsp_element_index;
   logic [CODE_W-1:0]   rsp_dac_code;
   logic [CMD_W-1:0]    rsp_command_byte;
   logic [BYTE_W-1:0]   rsp_high_byte;
   logic [BYTE_W-1:0]   rsp_low_byte;
   logic                rsp_end_of_run;

   phase_beat_type beats_to_send[$];
   dac_frame_type  frames_due[$];

   // predictor copy of the write-mode element counter
   logic [6:0]  write_index = '0;
   // the generator's own view of the counter, only to count live beats
   int          fill_index = 0;
   int          live_beats = 0;

   int          errors = 0;
   int          frames_seen = 0;
   int          beats_accepted = 0;
   int          cycles = 0;
   int          gap_left = 0;
   int          burst_left = 0;
   logic [7:0]  stall_cycle = '0;
   logic        beat_taken = 1'b0;
   logic        hold_off = 1'b0;

   phased_array_phase_to_dac_frames_top #(
      .ELEMENTS(N_ELEM)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_phase_value  (req_phase_value),
      .req_last_element (req_last_element),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_element_index(rsp_element_index),
      .rsp_dac_code     (rsp_dac_code),
      .rsp_command_byte (rsp_command_byte),
      .rsp_high_byte    (rsp_high_byte),
      .rsp_low_byte     (rsp_low_byte),
      .rsp_end_of_run   (rsp_end_of_run)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task automatic flag_error(input string msg);
      $display("error @%0t: %s", $time, msg);
      errors++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         flag_error($sformatf("frame %0d %s: got %0d, want %0d", frames_seen, name, got, want));
      end
   endtask

   // rounded 4095 * phase / half turn; top half of the turn saturates
   function automatic logic [CODE_W-1:0] phase_to_code(input logic [PHASE_W-1:0] phase);
      logic [26:0] scaled;
      scaled = 27'(phase) * 27'd4095 + 27'd16384;
      if (phase >= 16'h8000) begin
         return 12'hFFF;
      end
      return scaled[26:15];
   endfunction

   function automatic dac_frame_type make_frame(input int idx, input logic [PHASE_W-1:0] phase,
                                                input logic run_end);
      dac_frame_type f;
      f.index   = IDX_W'(idx);
      f.code    = phase_to_code(phase);
      f.cmd     = {CMD_WRITE_UPDATE, f.index[2:0]};
      f.hi      = f.code[11:4];
      f.lo      = {f.code[3:0], 4'h0};
      f.run_end = run_end;
      return f;
   endfunction

   // frames that one accepted request beat must produce
   task automatic predict_frames(input logic op, input logic [PHASE_W-1:0] phase,
                                 input logic last);
      logic [31:0] ramp;
      if (op == OP_STEER) begin
         for (int k = 0; k < N_ELEM; k++) begin
            ramp = k * phase;
            frames_due.push_back(make_frame(k, ramp[15:0], k == N_ELEM - 1));
         end
         write_index = '0;
      end else begin
         if (write_index < N_ELEM) begin
            frames_due.push_back(make_frame(write_index, phase, last));
            write_index = write_index + 7'd1;
         end
         // a last beat closes the update even when it was dropped
         if (last) begin
            write_index = '0;
         end
      end
   endtask

   task automatic add_beat(input logic op, input logic [PHASE_W-1:0] phase, input logic last);
      phase_beat_type b;
      b.op    = op;
      b.phase = phase;
      b.last  = last;
      beats_to_send.push_back(b);
      if (op == OP_STEER || fill_index < N_ELEM) begin
         live_beats++;
      end
      if (op == OP_STEER || last) begin
         fill_index = 0;
      end else if (fill_index < N_ELEM) begin
         fill_index++;
      end
   endtask

   // phases clustered on the rounding steps and around the half turn
   function automatic logic [PHASE_W-1:0] random_phase();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(32760, 32775));
         1: return 16'($urandom_range(0, 15));
         default: return 16'($urandom);
      endcase
   endfunction

   // stimulus, then wait for the pipeline to drain and give the verdict
   initial begin : stimulus
      int seq_kind;
      int run_len;
      logic first_seq;

      // directed: code extremes, rounding step, saturation, end flags, steers
      add_beat(OP_WRITE, 16'h0000, 1'b0);
      add_beat(OP_WRITE, 16'h0004, 1'b0);
      add_beat(OP_WRITE, 16'h0005, 1'b0);
      add_beat(OP_WRITE, 16'h7FFF, 1'b0);
      add_beat(OP_WRITE, 16'h8000, 1'b0);
      add_beat(OP_WRITE, 16'hFFFF, 1'b1);
      add_beat(OP_WRITE, 16'h4000, 1'b1);
      add_beat(OP_STEER, 16'h0000, 1'b0);
      add_beat(OP_WRITE, 16'h1111, 1'b0);
      add_beat(OP_WRITE, 16'h2222, 1'b0);
      // steer ignores the last flag and restarts the write counter
      add_beat(OP_STEER, 16'hFFFF, 1'b1);
      add_beat(OP_WRITE, 16'h3333, 1'b1);
      add_beat(OP_STEER, 16'h0400, 1'b0);
      add_beat(OP_STEER, 16'h8000, 1'b0);
      add_beat(OP_WRITE, 16'h0001, 1'b1);

      // random: mostly well-formed updates, the first one overflowing the array
      live_beats = 0;
      first_seq = 1'b1;
      while (live_beats < RANDOM_BEATS) begin
         seq_kind = first_seq ? 7 : $urandom_range(0, 9);
         first_seq = 1'b0;
         case (seq_kind)
            0, 1, 2, 3, 4, 5: begin
               run_len = $urandom_range(1, 12);
               for (int i = 0; i < run_len; i++) begin
                  add_beat(OP_WRITE, random_phase(), i == run_len - 1);
               end
            end
            6: add_beat(OP_STEER, random_phase(), 1'($urandom));
            7: begin
               // more elements than the array holds, closing last beat dropped
               run_len = N_ELEM + $urandom_range(1, 6);
               for (int i = 0; i < run_len; i++) begin
                  add_beat(OP_WRITE, random_phase(), i == run_len - 1);
               end
            end
            8: add_beat(1'($urandom), random_phase(), 1'($urandom));
            default: begin
               // open update, carried on by whatever comes next
               run_len = $urandom_range(1, 8);
               for (int i = 0; i < run_len; i++) begin
                  add_beat(OP_WRITE, random_phase(), 1'b0);
               end
            end
         endcase
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (beats_to_send.size() != 0 || req_valid) @(negedge clock);
      while (frames_due.size() != 0) @(negedge clock);
      // a little slack catches stray frames
      repeat (20) @(negedge clock);
      if (frames_due.size() != 0) begin
         flag_error($sformatf("%0d frames never arrived", frames_due.size()));
      end
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // sender: bursts of random length separated by random gaps
   always @(negedge clock) begin : send
      logic hold;
      logic offer;
      phase_beat_type nxt;
      if (beat_taken) begin
         nxt = beats_to_send.pop_front();
      end
      hold  = req_valid && !beat_taken;
      offer = hold;
      if (!hold && !reset) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (beats_to_send.size() != 0) begin
            offer = 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 20);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
      req_valid <= offer;
      if (!hold) begin
         if (offer) begin
            nxt = beats_to_send[0];
            req_operation    <= nxt.op;
            req_phase_value  <= nxt.phase;
            req_last_element <= nxt.last;
         end else begin
            // junk on the payload while idle
            req_operation    <= 1'($urandom);
            req_phase_value  <= 16'($urandom);
            req_last_element <= 1'($urandom);
         end
      end
   end

   // receiver: rotating stall pattern, overridden by the long hold-off
   always @(negedge clock) begin : receive
      logic ready;
      stall_cycle <= stall_cycle + 8'd1;
      case (stall_cycle[7:6])
         2'd0: ready = 1'b1;
         2'd1: ready = ($urandom_range(0, 3) != 0);
         2'd2: ready = ($urandom_range(0, 2) == 0);
         default: ready = (stall_cycle[2:0] != 3'b101);
      endcase
      rsp_ready <= ready && !hold_off && !reset;
   end

   // long stall on the result side so the block backs up into the request side
   initial begin : long_stall
      while (beats_accepted < 30) @(negedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_off <= 1'b0;
   end

   // monitor: check returned frames first, then predict from accepted beats
   always @(posedge clock) begin : watch
      dac_frame_type want;
      beat_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (frames_due.size() == 0) begin
               flag_error($sformatf("unexpected frame for element %0d", rsp_element_index));
            end else begin
               want = frames_due.pop_front();
               check_field("element_index", rsp_element_index, want.index);
               check_field("dac_code", rsp_dac_code, want.code);
               check_field("command_byte", rsp_command_byte, want.cmd);
               check_field("high_byte", rsp_high_byte, want.hi);
               check_field("low_byte", rsp_low_byte, want.lo);
               check_field("end_of_run", rsp_end_of_run, want.run_end);
            end
            frames_seen++;
         end
         if (req_valid && req_ready) begin
            predict_frames(req_operation, req_phase_value, req_last_element);
            beats_accepted++;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/padac_pkg.sv
hw/rtl/phased_array_phase_to_dac_frames_top.sv
tb/sv/phased_array_phase_to_dac_frames_top_tb.sv
